// ===== hdl/lidar_polar_to_cartesian_defines.svh =====
// ----------------------------------------------------------------------------
// Lidar polar to Cartesian converter - assertion macros
// Clocked property wrappers on aclk, disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef LIDAR_POLAR_TO_CARTESIAN_DEFINES_SVH
`define LIDAR_POLAR_TO_CARTESIAN_DEFINES_SVH

// same-cycle implication
`define LP2C_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LP2C_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/lp2c_pkg.sv =====
// ----------------------------------------------------------------------------
// lp2c_pkg
// Shared types, constants and trig helpers for the lidar point converter.
// ----------------------------------------------------------------------------
package lp2c_pkg;

    localparam int LASER_COUNT_DEF = 16;
    localparam int LANE_SPAN       = 32;   // channel field is 5 bits
    localparam int LANE_W          = 5;

    localparam int S_TDATA_W = 56;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 120;

    localparam int ELEV_MAX = 90;
    localparam int ELEV_MIN = -90;

    // azimuth / 100 as multiply by ceil(2^24 / 100), exact for 16-bit input
    localparam logic [17:0] AZ_RECIP = 18'd167773;
    localparam int          AZ_SHIFT = 24;
    localparam logic [9:0]  DEG_FULL = 10'd360;

    typedef enum logic [1:0] {
        ACT_CONVERT = 2'd0,
        ACT_ELEV_WR = 2'd1,
        ACT_CORR_WR = 2'd2
    } action_t;

    typedef struct packed {
        logic                elev_we;
        logic                corr_we;
        logic [LANE_W-1:0]   lane;
        logic signed [15:0]  value;
    } tbl_wr_t;

    // round(32768 * sin(k deg)), k = 0..90, 90 deg saturated
    localparam logic [15:0] SIN_Q15 [91] = '{
        16'd0,     16'd572,   16'd1144,  16'd1715,  16'd2286,
        16'd2856,  16'd3425,  16'd3993,  16'd4560,  16'd5126,
        16'd5690,  16'd6252,  16'd6813,  16'd7371,  16'd7927,
        16'd8481,  16'd9032,  16'd9580,  16'd10126, 16'd10668,
        16'd11207, 16'd11743, 16'd12275, 16'd12803, 16'd13328,
        16'd13848, 16'd14365, 16'd14876, 16'd15384, 16'd15886,
        16'd16384, 16'd16877, 16'd17364, 16'd17847, 16'd18324,
        16'd18795, 16'd19261, 16'd19720, 16'd20174, 16'd20622,
        16'd21063, 16'd21498, 16'd21926, 16'd22348, 16'd22763,
        16'd23170, 16'd23571, 16'd23965, 16'd24351, 16'd24730,
        16'd25102, 16'd25466, 16'd25822, 16'd26170, 16'd26510,
        16'd26842, 16'd27166, 16'd27482, 16'd27789, 16'd28088,
        16'd28378, 16'd28660, 16'd28932, 16'd29197, 16'd29452,
        16'd29698, 16'd29935, 16'd30163, 16'd30382, 16'd30592,
        16'd30792, 16'd30983, 16'd31164, 16'd31336, 16'd31499,
        16'd31652, 16'd31795, 16'd31928, 16'd32052, 16'd32166,
        16'd32270, 16'd32365, 16'd32449, 16'd32524, 16'd32589,
        16'd32644, 16'd32688, 16'd32723, 16'd32748, 16'd32763,
        16'd32767
    };

    // sine of a whole-degree angle 0..359 by quadrant folding
    function automatic logic signed [15:0] sin_deg(input logic [8:0] a);
        logic [8:0]  idx;
        logic        neg;
        logic [15:0] mag;
        if (a <= 9'd90) begin
            idx = a;
            neg = 1'b0;
        end else if (a <= 9'd180) begin
            idx = 9'd180 - a;
            neg = 1'b0;
        end else if (a <= 9'd270) begin
            idx = a - 9'd180;
            neg = 1'b1;
        end else begin
            idx = 9'd360 - a;
            neg = 1'b1;
        end
        mag = SIN_Q15[idx[6:0]];
        return neg ? -$signed(mag) : $signed(mag);
    endfunction

    // >> 22, round to nearest, ties away from zero
    function automatic logic signed [25:0] rnd_shr22(input logic signed [47:0] v);
        logic [47:0] m;
        logic [47:0] r;
        m = v[47] ? 48'(-v) : 48'(v);
        r = (m + 48'(1 << 21)) >> 22;
        return v[47] ? -$signed(26'(r)) : $signed(26'(r));
    endfunction

    // >> 7, round to nearest, ties away from zero
    function automatic logic signed [25:0] rnd_shr7(input logic signed [32:0] v);
        logic [32:0] m;
        logic [32:0] r;
        m = v[32] ? 33'(-v) : 33'(v);
        r = (m + 33'(1 << 6)) >> 7;
        return v[32] ? -$signed(26'(r)) : $signed(26'(r));
    endfunction

endpackage

// ===== hdl/lidar_polar_to_cartesian.sv =====
// ----------------------------------------------------------------------------
// lidar_polar_to_cartesian
// Converts lidar returns (azimuth, range, laser) into corrected x/y/z points.
// ----------------------------------------------------------------------------
// Usage:
//   Input words arrive on s_tvalid/s_tready/s_tdata/s_tuser. s_tuser holds the
//   action: convert a return, write an elevation entry or write a correction
//   entry for laser (channel mod LASER_COUNT). Action code 3 is dropped.
//   Result words leave on m_tvalid/m_tready/m_tdata, one per convert word whose
//   rounded uncorrected x, y and z are not all zero; other words give none.
//   Throughput is one word per cycle while m_tready is not held low: six
//   register stages (azimuth reciprocal multiply, trig lookup, range multiply,
//   trig multiply, rounding, correction add / output).
//   Table writes take effect at their accept edge, so a convert word in the
//   very next cycle already sees them.
//   Reset (aresetn low, synchronous) empties the pipeline and clears both
//   tables to zero. When the receiver holds m_tready low with a word pending,
//   the whole pipeline freezes and s_tready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
`include "lidar_polar_to_cartesian_defines.svh"

module lidar_polar_to_cartesian import lp2c_pkg::*; #(
    parameter int LASER_COUNT = LASER_COUNT_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // azimuth_hundredths[15:0], distance[31:16], channel[36:32],
    // table_value[52:37], zero[55:53]
    input  logic [S_TDATA_W-1:0] s_tdata,
    // action[1:0]
    input  logic [S_TUSER_W-1:0] s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // x_pos[25:0], y_pos[51:26], z_pos[77:52], azimuth_degrees[86:78],
    // range_echo[102:87], elevation_degrees[110:103], laser_index[114:111],
    // zero[119:115]
    output logic [M_TDATA_W-1:0] m_tdata
);

    // only lanes reachable by a 5-bit channel need storage
    localparam int TBL_DEPTH = (LASER_COUNT < LANE_SPAN) ? LASER_COUNT : LANE_SPAN;
    localparam int LIDX_W    = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;

    // ---------------- input unpack ----------------
    logic [15:0]        in_az;
    logic [15:0]        in_dist;
    logic [4:0]         in_chan;
    logic signed [15:0] in_tval;

    assign in_az   = s_tdata[15:0];
    assign in_dist = s_tdata[31:16];
    assign in_chan = s_tdata[36:32];
    assign in_tval = s_tdata[52:37];

    // pipeline advances whenever the output slot is free or being drained
    logic adv;
    logic acc;
    logic m_tvalid_reg;

    assign adv      = !m_tvalid_reg || m_tready;
    assign s_tready = adv;
    assign acc      = s_tvalid && adv;

    // channel -> lane, constant table built at elaboration
    logic [LIDX_W-1:0] lane_lut [LANE_SPAN];
    logic [LIDX_W-1:0] lane_cur;

    for (genvar g = 0; g < LANE_SPAN; g++) begin : g_lane
        assign lane_lut[g] = LIDX_W'(g % LASER_COUNT);
    end

    assign lane_cur = lane_lut[in_chan];

    // ---------------- tables ----------------
    tbl_wr_t            tbl_wr;
    logic signed [7:0]  el_rd;
    logic signed [15:0] corr_rd;

    assign tbl_wr.elev_we = acc && (s_tuser == ACT_ELEV_WR);
    assign tbl_wr.corr_we = acc && (s_tuser == ACT_CORR_WR);
    assign tbl_wr.lane    = LANE_W'(lane_cur);
    assign tbl_wr.value   = in_tval;

    lp2c_tables #(
        .TBL_DEPTH (TBL_DEPTH),
        .LIDX_W    (LIDX_W)
    ) u_tables (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (tbl_wr),
        .rd_lane (lane_cur),
        .rd_elev (el_rd),
        .rd_corr (corr_rd)
    );

    // ---------------- stage 1: azimuth / 100, table read ----------------
    logic [33:0]        az_prod;
    logic               s1_vld_next;
    logic [9:0]         s1_azq_next;
    logic               s1_vld_reg;
    logic [9:0]         s1_azq_reg;
    logic [15:0]        s1_dist_reg;
    logic [3:0]         s1_lane_reg;
    logic signed [7:0]  s1_el_reg;
    logic signed [15:0] s1_corr_reg;

    assign az_prod     = 34'(in_az) * 34'(AZ_RECIP);
    assign s1_azq_next = az_prod[AZ_SHIFT+9:AZ_SHIFT];
    assign s1_vld_next = acc && (s_tuser == ACT_CONVERT);

    // ---------------- stage 2: wrap to 0..359, trig lookups ----------------
    logic [8:0]         s2_az_next;
    logic [9:0]         caz_arg;
    logic [8:0]         caz_deg;
    logic [7:0]         el_mag;
    logic signed [15:0] sel_mag;
    logic signed [15:0] s2_saz_next;
    logic signed [15:0] s2_caz_next;
    logic signed [15:0] s2_sel_next;
    logic [14:0]        s2_cel_next;

    logic               s2_vld_reg;
    logic [8:0]         s2_az_reg;
    logic signed [15:0] s2_saz_reg;
    logic signed [15:0] s2_caz_reg;
    logic signed [15:0] s2_sel_reg;
    logic [14:0]        s2_cel_reg;
    logic [15:0]        s2_dist_reg;
    logic [3:0]         s2_lane_reg;
    logic signed [7:0]  s2_el_reg;
    logic signed [15:0] s2_corr_reg;

    always_comb begin
        if (s1_azq_reg >= DEG_FULL) begin
            s2_az_next = 9'(s1_azq_reg - DEG_FULL);
        end else begin
            s2_az_next = s1_azq_reg[8:0];
        end
        caz_arg = 10'(s2_az_next) + 10'd90;
        if (caz_arg >= DEG_FULL) begin
            caz_deg = 9'(caz_arg - DEG_FULL);
        end else begin
            caz_deg = caz_arg[8:0];
        end
        // stored elevations are already within +/-90
        el_mag      = s1_el_reg[7] ? 8'(-s1_el_reg) : 8'(s1_el_reg);
        sel_mag     = $signed(SIN_Q15[el_mag[6:0]]);
        s2_sel_next = s1_el_reg[7] ? -sel_mag : sel_mag;
        s2_cel_next = 15'(SIN_Q15[7'(7'd90 - el_mag[6:0])]);
        s2_saz_next = sin_deg(s2_az_next);
        s2_caz_next = sin_deg(caz_deg);
    end

    // ---------------- stage 3: range * cos(el), range * sin(el) ----------------
    logic [30:0]        s3_dc_next;
    logic signed [32:0] s3_dz_next;
    logic               s3_vld_reg;
    logic [30:0]        s3_dc_reg;
    logic signed [32:0] s3_dz_reg;
    logic signed [15:0] s3_saz_reg;
    logic signed [15:0] s3_caz_reg;
    logic [8:0]         s3_az_reg;
    logic [15:0]        s3_dist_reg;
    logic [3:0]         s3_lane_reg;
    logic signed [7:0]  s3_el_reg;
    logic signed [15:0] s3_corr_reg;

    assign s3_dc_next = 31'(s2_dist_reg) * 31'(s2_cel_reg);
    assign s3_dz_next = $signed({1'b0, s2_dist_reg}) * s2_sel_reg;

    // ---------------- stage 4: times sin/cos(az) ----------------
    logic signed [47:0] s4_px_next;
    logic signed [47:0] s4_py_next;
    logic               s4_vld_reg;
    logic signed [47:0] s4_px_reg;
    logic signed [47:0] s4_py_reg;
    logic signed [32:0] s4_pz_reg;
    logic [8:0]         s4_az_reg;
    logic [15:0]        s4_dist_reg;
    logic [3:0]         s4_lane_reg;
    logic signed [7:0]  s4_el_reg;
    logic signed [15:0] s4_corr_reg;

    assign s4_px_next = $signed({1'b0, s3_dc_reg}) * s3_saz_reg;
    assign s4_py_next = $signed({1'b0, s3_dc_reg}) * s3_caz_reg;

    // ---------------- stage 5: rounding, drop test ----------------
    logic signed [25:0] s5_rx_next;
    logic signed [25:0] s5_ry_next;
    logic signed [25:0] s5_rz_next;
    logic               s5_nz_next;
    logic               s5_vld_reg;
    logic               s5_nz_reg;
    logic signed [25:0] s5_rx_reg;
    logic signed [25:0] s5_ry_reg;
    logic signed [25:0] s5_rz_reg;
    logic [8:0]         s5_az_reg;
    logic [15:0]        s5_dist_reg;
    logic [3:0]         s5_lane_reg;
    logic signed [7:0]  s5_el_reg;
    logic signed [15:0] s5_corr_reg;

    assign s5_rx_next = rnd_shr22(s4_px_reg);
    assign s5_ry_next = rnd_shr22(s4_py_reg);
    assign s5_rz_next = rnd_shr7(s4_pz_reg);
    assign s5_nz_next = (s5_rx_next != '0) || (s5_ry_next != '0) || (s5_rz_next != '0);

    // ---------------- stage 6: correction add, output register ----------------
    logic signed [25:0]   corr_ext;
    logic signed [25:0]   x_fin;
    logic signed [25:0]   y_fin;
    logic signed [25:0]   z_fin;
    logic                 m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_next;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    assign corr_ext      = 26'(s5_corr_reg);
    assign x_fin         = s5_rx_reg + corr_ext;
    assign y_fin         = s5_ry_reg + corr_ext;
    assign z_fin         = s5_rz_reg + corr_ext;
    assign m_tvalid_next = s5_vld_reg && s5_nz_reg;
    assign m_tdata_next  = {5'b0, s5_lane_reg, s5_el_reg, s5_dist_reg, s5_az_reg,
                            z_fin, y_fin, x_fin};

    // ---------------- valid chain ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg   <= 1'b0;
            s2_vld_reg   <= 1'b0;
            s3_vld_reg   <= 1'b0;
            s4_vld_reg   <= 1'b0;
            s5_vld_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            s1_vld_reg   <= s1_vld_next;
            s2_vld_reg   <= s1_vld_reg;
            s3_vld_reg   <= s2_vld_reg;
            s4_vld_reg   <= s3_vld_reg;
            s5_vld_reg   <= s4_vld_reg;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // ---------------- payload ----------------
    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_azq_reg  <= s1_azq_next;
            s1_dist_reg <= in_dist;
            s1_lane_reg <= 4'(lane_cur);
            s1_el_reg   <= el_rd;
            s1_corr_reg <= corr_rd;

            s2_az_reg   <= s2_az_next;
            s2_saz_reg  <= s2_saz_next;
            s2_caz_reg  <= s2_caz_next;
            s2_sel_reg  <= s2_sel_next;
            s2_cel_reg  <= s2_cel_next;
            s2_dist_reg <= s1_dist_reg;
            s2_lane_reg <= s1_lane_reg;
            s2_el_reg   <= s1_el_reg;
            s2_corr_reg <= s1_corr_reg;

            s3_dc_reg   <= s3_dc_next;
            s3_dz_reg   <= s3_dz_next;
            s3_saz_reg  <= s2_saz_reg;
            s3_caz_reg  <= s2_caz_reg;
            s3_az_reg   <= s2_az_reg;
            s3_dist_reg <= s2_dist_reg;
            s3_lane_reg <= s2_lane_reg;
            s3_el_reg   <= s2_el_reg;
            s3_corr_reg <= s2_corr_reg;

            s4_px_reg   <= s4_px_next;
            s4_py_reg   <= s4_py_next;
            s4_pz_reg   <= s3_dz_reg;
            s4_az_reg   <= s3_az_reg;
            s4_dist_reg <= s3_dist_reg;
            s4_lane_reg <= s3_lane_reg;
            s4_el_reg   <= s3_el_reg;
            s4_corr_reg <= s3_corr_reg;

            s5_rx_reg   <= s5_rx_next;
            s5_ry_reg   <= s5_ry_next;
            s5_rz_reg   <= s5_rz_next;
            s5_nz_reg   <= s5_nz_next;
            s5_az_reg   <= s4_az_reg;
            s5_dist_reg <= s4_dist_reg;
            s5_lane_reg <= s4_lane_reg;
            s5_el_reg   <= s4_el_reg;
            s5_corr_reg <= s4_corr_reg;

            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // ---------------- checks ----------------
    // table clamp keeps every looked-up elevation in range
    `LP2C_ASSERT(a_elev_range, s1_vld_reg, (s1_el_reg >= ELEV_MIN) && (s1_el_reg <= ELEV_MAX), "elevation out of range")
    // azimuth wrap leaves whole degrees below a full turn
    `LP2C_ASSERT(a_az_wrap, m_tvalid, m_tdata[86:78] < 9'd360, "azimuth not wrapped")
    // a frozen pipeline keeps all its valid bits
    `LP2C_ASSERT_NXT(a_stall_freeze, !adv, $stable({s1_vld_reg, s2_vld_reg, s3_vld_reg, s4_vld_reg, s5_vld_reg}), "pipeline moved during stall")

endmodule

// ===== hdl/lp2c_tables.sv =====
// ----------------------------------------------------------------------------
// lp2c_tables
// Per-laser elevation and correction tables, cleared at reset.
// ----------------------------------------------------------------------------
module lp2c_tables import lp2c_pkg::*; #(
    parameter int TBL_DEPTH = LASER_COUNT_DEF,
    parameter int LIDX_W    = 4
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  tbl_wr_t            wr,
    input  logic [LIDX_W-1:0]  rd_lane,
    output logic signed [7:0]  rd_elev,
    output logic signed [15:0] rd_corr
);

    logic signed [7:0]  elev_reg [TBL_DEPTH];
    logic signed [15:0] corr_reg [TBL_DEPTH];
    logic signed [7:0]  elev_next;
    logic [LIDX_W-1:0]  wr_idx;

    assign wr_idx = wr.lane[LIDX_W-1:0];

    // elevation stored clamped to +/-90 deg
    always_comb begin
        if (wr.value > ELEV_MAX) begin
            elev_next = 8'(ELEV_MAX);
        end else if (wr.value < ELEV_MIN) begin
            elev_next = 8'(ELEV_MIN);
        end else begin
            elev_next = wr.value[7:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < TBL_DEPTH; i++) begin
                elev_reg[i] <= '0;
                corr_reg[i] <= '0;
            end
        end else begin
            if (wr.elev_we) begin
                elev_reg[wr_idx] <= elev_next;
            end
            if (wr.corr_we) begin
                corr_reg[wr_idx] <= wr.value;
            end
        end
    end

    assign rd_elev = elev_reg[rd_lane];
    assign rd_corr = corr_reg[rd_lane];

endmodule
